// ===== rtl/triangle_pixel_coverage_shader_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pixel coverage shader
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PIXEL_COVERAGE_SHADER_UNIT_ASSERT_SVH
`define TRIANGLE_PIXEL_COVERAGE_SHADER_UNIT_ASSERT_SVH

// Same-cycle implication
`define TPCS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TPCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tpcs_pkg
// Shared types, field widths and the colour level table of the shader.
// ----------------------------------------------------------------------------
package tpcs_pkg;

   localparam int CoordFieldBits = 12;
   localparam int VertBits       = 20;
   localparam int TriIdxBits     = 12;
   localparam int ChanBits       = 8;
   localparam int WidthBits      = 13;
   localparam int IndexBits      = 24;
   localparam logic [WidthBits-1:0] WidthReset = 13'd960;

   localparam logic [ChanBits-1:0] LevelTable [5] = '{8'd0, 8'd64, 8'd128, 8'd191, 8'd255};

   // per-stage advance strobes
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   typedef struct packed {
      logic neg;
      logic pos;
   } edge_sign_type;

   // count four interleaved index bits, starting at bit first, map to a level
   function automatic logic [ChanBits-1:0] channel_level(
      input logic [TriIdxBits-1:0] idx,
      input logic [1:0]            first
   );
      logic [2:0] n;
      n = 3'd0;
      for (int k = 0; k < 4; k++) begin
         n = n + 3'(idx[4'(first) + 4'(3 * k)]);
      end
      return LevelTable[n];
   endfunction

endpackage

// ===== rtl/tpcs_req_if.sv =====
// ----------------------------------------------------------------------------
// tpcs_req_if
// Request channel: pixel coordinate, triangle vertices and triangle index.
// ----------------------------------------------------------------------------
interface tpcs_req_if;
   logic                                       valid;
   logic                                       ready;
   logic        [tpcs_pkg::CoordFieldBits-1:0] pixel_x;
   logic        [tpcs_pkg::CoordFieldBits-1:0] pixel_y;
   logic signed [tpcs_pkg::VertBits-1:0]       vert_a_x;
   logic signed [tpcs_pkg::VertBits-1:0]       vert_a_y;
   logic signed [tpcs_pkg::VertBits-1:0]       vert_b_x;
   logic signed [tpcs_pkg::VertBits-1:0]       vert_b_y;
   logic signed [tpcs_pkg::VertBits-1:0]       vert_c_x;
   logic signed [tpcs_pkg::VertBits-1:0]       vert_c_y;
   logic        [tpcs_pkg::TriIdxBits-1:0]     tri_index;

   modport source (
      output valid, pixel_x, pixel_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
             vert_c_x, vert_c_y, tri_index,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
             vert_c_x, vert_c_y, tri_index,
      output ready
   );
endinterface

// ===== rtl/tpcs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tpcs_rsp_if
// Response channel: coverage flag, fill colour and frame buffer index.
// ----------------------------------------------------------------------------
interface tpcs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             covered;
   logic [tpcs_pkg::ChanBits-1:0]    red;
   logic [tpcs_pkg::ChanBits-1:0]    green;
   logic [tpcs_pkg::ChanBits-1:0]    blue;
   logic [tpcs_pkg::IndexBits-1:0]   pixel_index;

   modport source (
      output valid, covered, red, green, blue, pixel_index,
      input  ready
   );
   modport sink (
      input  valid, covered, red, green, blue, pixel_index,
      output ready
   );
endinterface

// ===== rtl/tpcs_edge.sv =====
// ----------------------------------------------------------------------------
// tpcs_edge
// Three-stage edge function (p - w) x (q - w): differences, products, sign.
// ----------------------------------------------------------------------------
module tpcs_edge #(
   parameter int PIX_BITS = 16
) (
   input  logic                                 clock,
   input  tpcs_pkg::stage_en_type               stage_en,
   input  logic        [PIX_BITS-1:0]           px,
   input  logic        [PIX_BITS-1:0]           py,
   input  logic signed [tpcs_pkg::VertBits-1:0] qx,
   input  logic signed [tpcs_pkg::VertBits-1:0] qy,
   input  logic signed [tpcs_pkg::VertBits-1:0] wx,
   input  logic signed [tpcs_pkg::VertBits-1:0] wy,
   output tpcs_pkg::edge_sign_type              sign
);

   localparam int PixSBits  = PIX_BITS + 1;
   localparam int DiffBits  = ((PixSBits > tpcs_pkg::VertBits) ? PixSBits
                                                              : tpcs_pkg::VertBits) + 1;
   localparam int VDiffBits = tpcs_pkg::VertBits + 1;
   localparam int ProdBits  = DiffBits + VDiffBits;
   localparam int EdgeBits  = ProdBits + 1;

   logic signed [PixSBits-1:0]  px_s;
   logic signed [PixSBits-1:0]  py_s;

   logic signed [DiffBits-1:0]  pxw_in,  pxw_ff;
   logic signed [DiffBits-1:0]  pyw_in,  pyw_ff;
   logic signed [VDiffBits-1:0] qxw_in,  qxw_ff;
   logic signed [VDiffBits-1:0] qyw_in,  qyw_ff;
   logic signed [ProdBits-1:0]  prod0_in, prod0_ff;
   logic signed [ProdBits-1:0]  prod1_in, prod1_ff;
   logic signed [EdgeBits-1:0]  edge_val;
   tpcs_pkg::edge_sign_type     sign_in, sign_ff;

   assign px_s = signed'({1'b0, px});
   assign py_s = signed'({1'b0, py});

   assign pxw_in = DiffBits'(px_s) - DiffBits'(wx);
   assign pyw_in = DiffBits'(py_s) - DiffBits'(wy);
   assign qxw_in = VDiffBits'(qx) - VDiffBits'(wx);
   assign qyw_in = VDiffBits'(qy) - VDiffBits'(wy);

   assign prod0_in = ProdBits'(pxw_ff) * ProdBits'(qyw_ff);
   assign prod1_in = ProdBits'(qxw_ff) * ProdBits'(pyw_ff);

   assign edge_val    = EdgeBits'(prod0_ff) - EdgeBits'(prod1_ff);
   assign sign_in.neg = edge_val[EdgeBits-1];
   assign sign_in.pos = !edge_val[EdgeBits-1] && (edge_val != '0);

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         pxw_ff <= pxw_in;
         pyw_ff <= pyw_in;
         qxw_ff <= qxw_in;
         qyw_ff <= qyw_in;
      end
      if (stage_en.s2) begin
         prod0_ff <= prod0_in;
         prod1_ff <= prod1_in;
      end
      if (stage_en.s3) begin
         sign_ff <= sign_in;
      end
   end

   assign sign = sign_ff;

endmodule

// ===== rtl/tpcs_pixel.sv =====
// ----------------------------------------------------------------------------
// tpcs_pixel
// Three-stage frame buffer index y * width + x; carries the triangle index.
// ----------------------------------------------------------------------------
module tpcs_pixel #(
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  tpcs_pkg::stage_en_type              stage_en,
   input  logic [COORD_BITS-1:0]               pixel_x,
   input  logic [COORD_BITS-1:0]               pixel_y,
   input  logic [tpcs_pkg::TriIdxBits-1:0]     tri_index,
   input  logic [tpcs_pkg::WidthBits-1:0]      frame_width,
   output logic [tpcs_pkg::IndexBits-1:0]      pixel_index,
   output logic [tpcs_pkg::TriIdxBits-1:0]     tri_index_out
);

   localparam int ProdBits = COORD_BITS + tpcs_pkg::WidthBits;
   localparam int SumBits  = ProdBits + 1;

   logic [COORD_BITS-1:0]             ux1_ff, ux2_ff;
   logic [COORD_BITS-1:0]             uy1_ff;
   logic [tpcs_pkg::WidthBits-1:0]    width1_ff;
   logic [tpcs_pkg::TriIdxBits-1:0]   idx1_ff, idx2_ff, idx3_ff;
   logic [ProdBits-1:0]               prod_in, prod_ff;
   logic [tpcs_pkg::IndexBits-1:0]    index_in, index_ff;

   assign prod_in  = ProdBits'(uy1_ff) * ProdBits'(width1_ff);
   assign index_in = tpcs_pkg::IndexBits'(SumBits'(prod_ff) + SumBits'(ux2_ff));

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         ux1_ff    <= pixel_x;
         uy1_ff    <= pixel_y;
         width1_ff <= frame_width;
         idx1_ff   <= tri_index;
      end
      if (stage_en.s2) begin
         prod_ff <= prod_in;
         ux2_ff  <= ux1_ff;
         idx2_ff <= idx1_ff;
      end
      if (stage_en.s3) begin
         index_ff <= index_in;
         idx3_ff  <= idx2_ff;
      end
   end

   assign pixel_index   = index_ff;
   assign tri_index_out = idx3_ff;

endmodule

// ===== rtl/triangle_pixel_coverage_shader_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_pixel_coverage_shader_unit
// Edge-function point-in-triangle test with index-derived fill color.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one pixel (x, y), three vertices in signed fixed point
//   with FRAC_BITS fraction bits and a triangle index. rsp_chan returns the
//   coverage flag, the fill color (zero when uncovered) and the frame buffer
//   index y * frame_width + x, low 24 bits.
//   csr_wr_en / csr_wr_data write frame_width; write it only while idle.
// Stages: four register stages (difference, product, edge sign / index sum,
//   output register). Throughput: one transaction per cycle while
//   rsp_chan.ready is high; each of the four stages is bounded by one 21x21
//   multiply or one 43-bit subtract and compare.
// Reset: clears all stage valid bits and loads frame_width with 960.
// Stall: when rsp_chan.ready is low the output register holds; earlier stages
//   keep filling until the first occupied stage, so req_chan.ready drops only
//   once every stage holds a transaction. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "triangle_pixel_coverage_shader_unit_assert.svh"

module triangle_pixel_coverage_shader_unit #(
   parameter int FRAC_BITS        = 4,
   parameter int PIXEL_COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   tpcs_req_if.sink                          req_chan,
   tpcs_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [tpcs_pkg::WidthBits-1:0]    csr_wr_data
);

   localparam int CoordBits = (PIXEL_COORD_BITS < tpcs_pkg::CoordFieldBits) ?
                              PIXEL_COORD_BITS : tpcs_pkg::CoordFieldBits;
   localparam int PixBits   = CoordBits + FRAC_BITS;

   logic [tpcs_pkg::WidthBits-1:0]   frame_width_in, frame_width_ff;
   logic                             v1_in, v1_ff;
   logic                             v2_in, v2_ff;
   logic                             v3_in, v3_ff;
   logic                             v4_in, v4_ff;
   tpcs_pkg::stage_en_type           stage_en;

   logic [CoordBits-1:0]             ux;
   logic [CoordBits-1:0]             uy;
   logic [PixBits-1:0]               px_fix;
   logic [PixBits-1:0]               py_fix;

   tpcs_pkg::edge_sign_type          sign0, sign1, sign2;
   logic [tpcs_pkg::IndexBits-1:0]   index3;
   logic [tpcs_pkg::TriIdxBits-1:0]  idx3;

   logic                             covered_in, covered_ff;
   logic [tpcs_pkg::ChanBits-1:0]    red_in, red_ff;
   logic [tpcs_pkg::ChanBits-1:0]    green_in, green_ff;
   logic [tpcs_pkg::ChanBits-1:0]    blue_in, blue_ff;
   logic [tpcs_pkg::IndexBits-1:0]   index_ff;

   // a stage advances when it is empty or its successor advances
   assign stage_en.s4 = !v4_ff || rsp_chan.ready;
   assign stage_en.s3 = !v3_ff || stage_en.s4;
   assign stage_en.s2 = !v2_ff || stage_en.s3;
   assign stage_en.s1 = !v1_ff || stage_en.s2;

   assign req_chan.ready = stage_en.s1;

   assign v1_in = stage_en.s1 ? req_chan.valid : v1_ff;
   assign v2_in = stage_en.s2 ? v1_ff : v2_ff;
   assign v3_in = stage_en.s3 ? v2_ff : v3_ff;
   assign v4_in = stage_en.s4 ? v3_ff : v4_ff;

   assign frame_width_in = csr_wr_en ? csr_wr_data : frame_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         v4_ff          <= 1'b0;
         frame_width_ff <= tpcs_pkg::WidthReset;
      end else begin
         v1_ff          <= v1_in;
         v2_ff          <= v2_in;
         v3_ff          <= v3_in;
         v4_ff          <= v4_in;
         frame_width_ff <= frame_width_in;
      end
   end

   // drop coordinate bits above the configured width, scale to fixed point
   assign ux     = req_chan.pixel_x[CoordBits-1:0];
   assign uy     = req_chan.pixel_y[CoordBits-1:0];
   assign px_fix = PixBits'(ux) << FRAC_BITS;
   assign py_fix = PixBits'(uy) << FRAC_BITS;

   tpcs_edge #(.PIX_BITS(PixBits)) u_edge_ab (
      .clock    (clock),
      .stage_en (stage_en),
      .px       (px_fix),
      .py       (py_fix),
      .qx       (req_chan.vert_a_x),
      .qy       (req_chan.vert_a_y),
      .wx       (req_chan.vert_b_x),
      .wy       (req_chan.vert_b_y),
      .sign     (sign0)
   );

   tpcs_edge #(.PIX_BITS(PixBits)) u_edge_bc (
      .clock    (clock),
      .stage_en (stage_en),
      .px       (px_fix),
      .py       (py_fix),
      .qx       (req_chan.vert_b_x),
      .qy       (req_chan.vert_b_y),
      .wx       (req_chan.vert_c_x),
      .wy       (req_chan.vert_c_y),
      .sign     (sign1)
   );

   tpcs_edge #(.PIX_BITS(PixBits)) u_edge_ca (
      .clock    (clock),
      .stage_en (stage_en),
      .px       (px_fix),
      .py       (py_fix),
      .qx       (req_chan.vert_c_x),
      .qy       (req_chan.vert_c_y),
      .wx       (req_chan.vert_a_x),
      .wy       (req_chan.vert_a_y),
      .sign     (sign2)
   );

   tpcs_pixel #(.COORD_BITS(CoordBits)) u_pixel (
      .clock         (clock),
      .stage_en      (stage_en),
      .pixel_x       (ux),
      .pixel_y       (uy),
      .tri_index     (req_chan.tri_index),
      .frame_width   (frame_width_ff),
      .pixel_index   (index3),
      .tri_index_out (idx3)
   );

   // covered unless edges disagree in strict sign
   assign covered_in = !((sign0.neg || sign1.neg || sign2.neg) &&
                         (sign0.pos || sign1.pos || sign2.pos));
   assign red_in   = covered_in ? tpcs_pkg::channel_level(idx3, 2'd0) : '0;
   assign green_in = covered_in ? tpcs_pkg::channel_level(idx3, 2'd1) : '0;
   assign blue_in  = covered_in ? tpcs_pkg::channel_level(idx3, 2'd2) : '0;

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         covered_ff <= covered_in;
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
         index_ff   <= index3;
      end
   end

   assign rsp_chan.valid       = v4_ff;
   assign rsp_chan.covered     = covered_ff;
   assign rsp_chan.red         = red_ff;
   assign rsp_chan.green       = green_ff;
   assign rsp_chan.blue        = blue_ff;
   assign rsp_chan.pixel_index = index_ff;

   `TPCS_ASSERT_IMP(a_uncovered_black, rsp_chan.valid && !rsp_chan.covered, (rsp_chan.red == '0) && (rsp_chan.green == '0) && (rsp_chan.blue == '0), "uncovered pixel has nonzero color")
   `TPCS_ASSERT_NEXT(a_accept_fills_s1, req_chan.valid && req_chan.ready, v1_ff, "accepted transaction not in first stage")
   `TPCS_ASSERT_NEXT(a_s2_holds, v2_ff && !stage_en.s3, v2_ff, "stalled second stage lost its transaction")
   `TPCS_ASSERT_IMP(a_ready_full, !req_chan.ready, v1_ff && v2_ff && v3_ff && v4_ff, "input stalled with a free stage")

endmodule
